### src/mdvj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdvj_pkg
// shared types, constants and widths of the motion delta virtual joystick
// ----------------------------------------------------------------------------
package mdvj_pkg;

    // fixed-point format of the axis state
    localparam int FRAC_BITS = 8;

    localparam int SUM_W    = 16;
    localparam int AXIS_W   = 16 + FRAC_BITS;
    localparam int GAIN_W   = 33;
    localparam int GAIN_LSH = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int GAIN_RSH = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
    localparam int ACC_W    = 26 + FRAC_BITS;
    localparam int WIDE_W   = ACC_W + GAIN_RSH;
    localparam int GAIN_BIAS = (1 << GAIN_RSH) - 1;

    localparam int DECAY_W  = 9;
    localparam int DECAY_SH = 8;
    localparam int DEC_P_W  = AXIS_W + DECAY_W + 1;
    localparam int DEC_BIAS = (1 << DECAY_SH) - 1;
    localparam logic [DECAY_W-1:0] DECAY_ONE = 9'd256;

    localparam int OUT_BIAS = (1 << FRAC_BITS) - 1;

    // shared multiplier operand widths
    localparam int MUL_A_W = AXIS_W;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int MOTION_BIT = 7;
    localparam logic MODE_RECENTER = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN  = 3'd0,
        CFG_DEADZONE    = 3'd1,
        CFG_SENSITIVITY = 3'd2,
        CFG_AXIS_LOWER  = 3'd3,
        CFG_AXIS_UPPER  = 3'd4,
        CFG_EDGE_ZONE   = 3'd5,
        CFG_DECAY       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        [6:0]  window_len;
        logic        [14:0] deadzone;
        logic        [15:0] sensitivity;
        logic signed [15:0] axis_lower;
        logic signed [15:0] axis_upper;
        logic        [14:0] edge_zone;
        logic        [8:0]  decay;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        window_len:  7'd4,
        deadzone:    15'd2,
        sensitivity: 16'd256,
        axis_lower:  16'sh8001,
        axis_upper:  16'sh7FFF,
        edge_zone:   15'd0,
        decay:       9'd256
    };

    // command passed from front to back
    typedef struct packed {
        logic               recenter;
        logic               motion;
        logic signed [15:0] sum_x;
        logic signed [15:0] sum_y;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_CLAMP,
        ST_DECAY,
        ST_STORE,
        ST_EMIT
    } t_back_state;

endpackage

### src/mdvj_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdvj_in_if
// input channel: motion samples and recenter requests
// ----------------------------------------------------------------------------
interface mdvj_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic        [7:0]  motion_status;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;

    modport source (output valid, mode, motion_status, delta_x, delta_y, input ready);
    modport sink   (input valid, mode, motion_status, delta_x, delta_y, output ready);
endinterface

### src/mdvj_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdvj_out_if
// output channel: integer axes and moved flag per window
// ----------------------------------------------------------------------------
interface mdvj_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] axis_x_out;
    logic signed [15:0] axis_y_out;
    logic               moved;

    modport source (output valid, axis_x_out, axis_y_out, moved, input ready);
    modport sink   (input valid, axis_x_out, axis_y_out, moved, output ready);
endinterface

### src/mdvj_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdvj_front
// accepts items, accumulates window sums, issues window and recenter commands
// ----------------------------------------------------------------------------
module mdvj_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdvj_pkg::t_cfg    i_cfg,
    mdvj_in_if.sink           i_in,
    input  logic              i_q_full,
    output logic              o_q_push,
    output mdvj_pkg::t_cmd    o_q_cmd
);

    logic signed [15:0] r_sum_x, n_sum_x;
    logic signed [15:0] r_sum_y, n_sum_y;
    logic        [6:0]  r_count, n_count;
    logic               r_motion, n_motion;

    logic               accept;
    logic               recenter;
    logic               hit;
    logic signed [15:0] acc_x, acc_y;
    logic        [6:0]  cnt_inc;
    logic        [6:0]  win_len;
    logic               win_end;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15]) begin
            return s[16] ? 16'sh8000 : 16'sh7FFF;
        end
        return s[15:0];
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign recenter   = (i_in.mode == mdvj_pkg::MODE_RECENTER);
    assign hit        = i_in.motion_status[mdvj_pkg::MOTION_BIT];

    always_comb begin
        acc_x   = hit ? sat_add(r_sum_x, i_in.delta_x) : r_sum_x;
        acc_y   = hit ? sat_add(r_sum_y, i_in.delta_y) : r_sum_y;
        cnt_inc = r_count + 7'd1;
        // zero length acts as one
        win_len = (i_cfg.window_len == 7'd0) ? 7'd1 : i_cfg.window_len;
        win_end = (cnt_inc >= win_len);
    end

    always_comb begin
        o_q_push         = accept && (recenter || win_end);
        o_q_cmd.recenter = recenter;
        o_q_cmd.motion   = r_motion || hit;
        o_q_cmd.sum_x    = acc_x;
        o_q_cmd.sum_y    = acc_y;
    end

    always_comb begin
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_count  = r_count;
        n_motion = r_motion;
        if (accept && !recenter) begin
            if (win_end) begin
                n_sum_x  = '0;
                n_sum_y  = '0;
                n_count  = '0;
                n_motion = 1'b0;
            end else begin
                n_sum_x  = acc_x;
                n_sum_y  = acc_y;
                n_count  = cnt_inc;
                n_motion = r_motion || hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_count  <= '0;
            r_motion <= 1'b0;
        end else begin
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
            r_count  <= n_count;
            r_motion <= n_motion;
        end
    end

endmodule

### src/mdvj_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdvj_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
module mdvj_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mdvj_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output mdvj_pkg::t_cmd    o_cmd
);

    mdvj_pkg::t_cmd r_mem [mdvj_pkg::QUEUE_DEPTH];

    logic [mdvj_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [mdvj_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [mdvj_pkg::Q_CNT_W-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == mdvj_pkg::Q_CNT_W'(mdvj_pkg::QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [mdvj_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [mdvj_pkg::Q_PTR_W-1:0] p);
        if (p == mdvj_pkg::Q_PTR_W'(mdvj_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + mdvj_pkg::Q_PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = do_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + mdvj_pkg::Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - mdvj_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### src/mdvj_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdvj_back
// axis update sequencer: one shared multiplier for gain and decay, output reg
// ----------------------------------------------------------------------------
module mdvj_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdvj_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  mdvj_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    mdvj_out_if.source        o_out
);

    localparam int AW = mdvj_pkg::AXIS_W;
    localparam int CW = mdvj_pkg::ACC_W;
    localparam int WW = mdvj_pkg::WIDE_W;
    localparam int GW = mdvj_pkg::GAIN_W;
    localparam int DW = mdvj_pkg::DEC_P_W;

    mdvj_pkg::t_back_state r_state, n_state;

    logic                                r_sel;
    logic signed [15:0]                  r_sum_x, r_sum_y;
    logic                                r_moved;
    logic signed [AW-1:0]                r_axis_x, r_axis_y;
    logic signed [mdvj_pkg::MUL_P_W-1:0] r_prod;
    logic signed [AW-1:0]                r_acc;
    logic                                r_dec;
    logic                                r_out_valid;
    logic signed [15:0]                  r_out_x, r_out_y;
    logic                                r_out_moved;

    logic                                slot_free;
    logic                                out_load;
    logic                                take_cmd;

    logic signed [15:0]                  sum_sel;
    logic signed [AW-1:0]                axis_sel;
    logic        [16:0]                  sum_ext, sum_mag;
    logic signed [15:0]                  gain_sum;
    logic        [mdvj_pkg::DECAY_W-1:0] decay_eff;
    logic signed [mdvj_pkg::MUL_A_W-1:0] mul_a;
    logic signed [mdvj_pkg::MUL_B_W-1:0] mul_b;
    logic signed [mdvj_pkg::MUL_P_W-1:0] mul_p;

    logic signed [GW-1:0]                gain_p;
    logic signed [WW-1:0]                gain_wide, gain_bias, step_w;
    logic signed [CW-1:0]                step, axis_ext, acc_sum, lim_lo, lim_hi, clamped;

    logic        [AW:0]                  acc_ext, acc_mag, edge_lim;
    logic                                use_decay;
    logic signed [DW-1:0]                dec_p, dec_bias, dec_sh;
    logic signed [AW-1:0]                new_axis;

    logic signed [AW-1:0]                out_bias_x, out_bias_y, out_sh_x, out_sh_y;

    assign slot_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mdvj_pkg::ST_IDLE: begin
                if (i_q_valid && !i_q_cmd.recenter) begin
                    n_state = i_q_cmd.motion ? mdvj_pkg::ST_GAIN : mdvj_pkg::ST_EMIT;
                end
            end
            mdvj_pkg::ST_GAIN:  n_state = mdvj_pkg::ST_CLAMP;
            mdvj_pkg::ST_CLAMP: n_state = mdvj_pkg::ST_DECAY;
            mdvj_pkg::ST_DECAY: n_state = mdvj_pkg::ST_STORE;
            mdvj_pkg::ST_STORE: n_state = r_sel ? mdvj_pkg::ST_EMIT : mdvj_pkg::ST_GAIN;
            mdvj_pkg::ST_EMIT: begin
                if (slot_free) begin
                    n_state = mdvj_pkg::ST_IDLE;
                end
            end
            default: n_state = mdvj_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        take_cmd = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            mdvj_pkg::ST_IDLE: take_cmd = i_q_valid;
            mdvj_pkg::ST_EMIT: out_load = slot_free;
            default: begin
                take_cmd = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign o_q_pop = take_cmd;

    // operand select, deadzone
    always_comb begin
        sum_sel   = r_sel ? r_sum_y : r_sum_x;
        axis_sel  = r_sel ? r_axis_y : r_axis_x;
        sum_ext   = {sum_sel[15], sum_sel};
        sum_mag   = sum_sel[15] ? (17'd0 - sum_ext) : sum_ext;
        gain_sum  = (sum_mag < {2'b00, i_cfg.deadzone}) ? 16'sd0 : sum_sel;
        decay_eff = (i_cfg.decay > mdvj_pkg::DECAY_ONE) ? mdvj_pkg::DECAY_ONE : i_cfg.decay;
    end

    // shared multiplier
    always_comb begin
        if (r_state == mdvj_pkg::ST_DECAY) begin
            mul_a = r_acc;
            mul_b = {{(mdvj_pkg::MUL_B_W - mdvj_pkg::DECAY_W){1'b0}}, decay_eff};
        end else begin
            mul_a = {{(mdvj_pkg::MUL_A_W - mdvj_pkg::SUM_W){gain_sum[15]}}, gain_sum};
            mul_b = {{(mdvj_pkg::MUL_B_W - 16){1'b0}}, i_cfg.sensitivity};
        end
        mul_p = mul_a * mul_b;
    end

    // gain step to axis format, add, clamp
    always_comb begin
        gain_p    = r_prod[GW-1:0];
        gain_wide = {{(WW - GW){gain_p[GW-1]}}, gain_p};
        gain_bias = gain_p[GW-1] ? WW'(mdvj_pkg::GAIN_BIAS) : '0;
        step_w    = ((gain_wide + gain_bias) <<< mdvj_pkg::GAIN_LSH) >>> mdvj_pkg::GAIN_RSH;
        step      = step_w[CW-1:0];
        axis_ext  = {{(CW - AW){axis_sel[AW-1]}}, axis_sel};
        acc_sum   = axis_ext + step;
        lim_lo    = {{(CW - 16){i_cfg.axis_lower[15]}}, i_cfg.axis_lower};
        lim_lo    = lim_lo <<< mdvj_pkg::FRAC_BITS;
        lim_hi    = {{(CW - 16){i_cfg.axis_upper[15]}}, i_cfg.axis_upper};
        lim_hi    = lim_hi <<< mdvj_pkg::FRAC_BITS;
        // lower limit first, upper wins when crossed
        clamped = acc_sum;
        if (clamped < lim_lo) begin
            clamped = lim_lo;
        end
        if (clamped > lim_hi) begin
            clamped = lim_hi;
        end
    end

    // edge zone test and decay rounding toward zero
    always_comb begin
        acc_ext   = {r_acc[AW-1], r_acc};
        acc_mag   = r_acc[AW-1] ? ('0 - acc_ext) : acc_ext;
        edge_lim  = {2'b00, i_cfg.edge_zone, {mdvj_pkg::FRAC_BITS{1'b0}}};
        use_decay = (acc_mag < edge_lim);
        dec_p     = r_prod[DW-1:0];
        dec_bias  = dec_p[DW-1] ? DW'(mdvj_pkg::DEC_BIAS) : '0;
        dec_sh    = (dec_p + dec_bias) >>> mdvj_pkg::DECAY_SH;
        new_axis  = r_dec ? dec_sh[AW-1:0] : r_acc;
    end

    // integer part of the axes, toward zero
    always_comb begin
        out_bias_x = r_axis_x[AW-1] ? AW'(mdvj_pkg::OUT_BIAS) : '0;
        out_bias_y = r_axis_y[AW-1] ? AW'(mdvj_pkg::OUT_BIAS) : '0;
        out_sh_x   = (r_axis_x + out_bias_x) >>> mdvj_pkg::FRAC_BITS;
        out_sh_y   = (r_axis_y + out_bias_y) >>> mdvj_pkg::FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mdvj_pkg::ST_IDLE;
            r_sel       <= 1'b0;
            r_axis_x    <= '0;
            r_axis_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take_cmd) begin
                r_sel <= 1'b0;
                if (i_q_cmd.recenter) begin
                    r_axis_x <= '0;
                    r_axis_y <= '0;
                end
            end
            if (r_state == mdvj_pkg::ST_STORE) begin
                r_sel <= !r_sel;
                if (r_sel) begin
                    r_axis_y <= new_axis;
                end else begin
                    r_axis_x <= new_axis;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take_cmd) begin
            r_sum_x <= i_q_cmd.sum_x;
            r_sum_y <= i_q_cmd.sum_y;
            r_moved <= i_q_cmd.motion;
        end
        if (r_state == mdvj_pkg::ST_GAIN || r_state == mdvj_pkg::ST_DECAY) begin
            r_prod <= mul_p;
        end
        if (r_state == mdvj_pkg::ST_CLAMP) begin
            r_acc <= clamped[AW-1:0];
        end
        if (r_state == mdvj_pkg::ST_DECAY) begin
            r_dec <= use_decay;
        end
        if (out_load) begin
            r_out_x     <= out_sh_x[15:0];
            r_out_y     <= out_sh_y[15:0];
            r_out_moved <= r_moved;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.axis_x_out = r_out_x;
    assign o_out.axis_y_out = r_out_y;
    assign o_out.moved      = r_out_moved;

endmodule

### src/motion_delta_virtual_joystick_unit.sv
`timescale 1ns / 1ps
// results: a window-closing sample with motion passes the queue and the back end's gain,
//   clamp, decay and store steps, one without motion only the queue and the emit state; recenter gives no result
// throughput: one item per cycle while the command queue has room; the back end works
//   through four steps per axis (two multiplies) on a motion window and takes a recenter in its idle state
// reset: synchronous active low, clears sums, counters, axes, queue and output valid,
//   and loads the register defaults
// ----------------------------------------------------------------------------
// motion_delta_virtual_joystick_unit
// turns windows of motion sensor deltas into two fixed-point joystick axes
// ----------------------------------------------------------------------------
module motion_delta_virtual_joystick_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mdvj_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mdvj_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mdvj_in_if.sink                            i_in,
    mdvj_out_if.source                         o_out
);

    // configuration registers
    mdvj_pkg::t_cfg r_cfg;

    // front to queue, queue to back
    logic           q_push;
    mdvj_pkg::t_cmd q_cmd;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    mdvj_pkg::t_cmd q_head;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mdvj_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (mdvj_pkg::t_cfg_idx'(i_cfg_idx))
                mdvj_pkg::CFG_WINDOW_LEN:  r_cfg.window_len  <= i_cfg_data[6:0];
                mdvj_pkg::CFG_DEADZONE:    r_cfg.deadzone    <= i_cfg_data[14:0];
                mdvj_pkg::CFG_SENSITIVITY: r_cfg.sensitivity <= i_cfg_data;
                mdvj_pkg::CFG_AXIS_LOWER:  r_cfg.axis_lower  <= i_cfg_data;
                mdvj_pkg::CFG_AXIS_UPPER:  r_cfg.axis_upper  <= i_cfg_data;
                mdvj_pkg::CFG_EDGE_ZONE:   r_cfg.edge_zone   <= i_cfg_data[14:0];
                mdvj_pkg::CFG_DECAY:       r_cfg.decay       <= i_cfg_data[8:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // front: takes every transfer, keeps the window sums
    mdvj_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd)
    );

    // queue lets the front run on while the back works or the output stalls
    mdvj_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_head)
    );

    // back: axis state, gain, clamp, decay and the output register
    mdvj_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_head),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

`ifndef NO_ASSERTIONS
    // front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // a recenter transfer always issues a recenter command
    a_recenter_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.mode == mdvj_pkg::MODE_RECENTER)
        |-> (q_push && q_cmd.recenter))
        else $error("recenter transfer without recenter command");

    // a window without motion carries empty sums
    a_idle_window_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_cmd.recenter && !q_cmd.motion)
        |-> (q_cmd.sum_x == 16'sd0 && q_cmd.sum_y == 16'sd0))
        else $error("window without motion has nonzero sums");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule
